// ===== design/sgmltok_pkg.sv =====
// Shared types, constants and helper functions of the SGML document tokenizer.
// Depends on nothing; the top level sgml_document_tokenizer uses it.
package sgmltok_pkg;

    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int OUT_COUNT_BITS     = 24;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_BITS         = 64;

    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [2:0] TAG_DOC_LEN = 3'd3;
    localparam logic [2:0] TAG_DOCNO_LEN = 3'd5;

    typedef enum logic [1:0] {
        MODE_SKIP = 2'd0,
        MODE_TERM = 2'd1,
        MODE_NAME = 2'd2,
        MODE_TAG  = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_TERM_BYTE = 3'd0,
        KIND_TERM_END  = 3'd1,
        KIND_NAME_BYTE = 3'd2,
        KIND_NAME_END  = 3'd3,
        KIND_DOC_LEN   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                char_out;
        logic [OUT_COUNT_BITS-1:0] doc_number;
        logic                      in_document;
        logic [OUT_COUNT_BITS-1:0] doc_length;
        logic                      last;
    } result_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
                || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            to_lower = c + 8'd32;
        end
        else
        begin
            to_lower = c;
        end
    endfunction

    // Characters of "DOCNO" that follow the opening bracket.
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        case (idx)
            3'd0:    tag_char = 8'h44;
            3'd1:    tag_char = 8'h4F;
            3'd2:    tag_char = 8'h43;
            3'd3:    tag_char = 8'h4E;
            3'd4:    tag_char = 8'h4F;
            default: tag_char = 8'h00;
        endcase
    endfunction

    function automatic result_t make_result(
        input kind_t                     kind,
        input logic [7:0]                ch,
        input logic [OUT_COUNT_BITS-1:0] dn,
        input logic                      ind,
        input logic [OUT_COUNT_BITS-1:0] len
    );
        result_t r;
        r.kind        = kind;
        r.char_out    = ch;
        r.doc_number  = dn;
        r.in_document = ind;
        r.doc_length  = len;
        r.last        = 1'b0;
        make_result   = r;
    endfunction

endpackage

// ===== design/sgml_document_tokenizer.sv =====
// Top level of the SGML document tokenizer: scanner state and a small result queue.
// Depends on sgmltok_pkg.
//
// The tokenizer takes one text byte per beat and can accept a beat in every cycle. Each
// beat is decoded in the cycle it is accepted, and its zero, one or two results are
// written into a four-entry result queue that drives the output stream one result per
// cycle while m_tready is high; the first result of a beat is offered in the next cycle
// if the queue was empty. Only an end-of-input beat that finds a term or a name open gives
// two results; every other beat gives at most one, so bytes flow at one per cycle while
// the output keeps up, and a two-result beat can hold the input back while the queue catches
// up. s_tready is low while fewer than two entries are free. No startup or clearing phase.
module sgml_document_tokenizer #(
    parameter int COUNT_BITS = sgmltok_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // char_out, doc_number, in_document, doc_length, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);

    localparam int OUTB     = sgmltok_pkg::OUT_COUNT_BITS;
    localparam int EXT_BITS = (COUNT_BITS > OUTB) ? COUNT_BITS : OUTB;
    localparam int PAD_BITS = sgmltok_pkg::TDATA_BITS - 8 - 2 * OUTB - 1;
    localparam int DEPTH    = sgmltok_pkg::QUEUE_DEPTH;
    localparam int PTRB     = sgmltok_pkg::QUEUE_PTR_BITS;
    localparam int CNTB     = sgmltok_pkg::QUEUE_CNT_BITS;

    sgmltok_pkg::scan_mode_t mode_reg, mode_next;
    logic [2:0]              match_len_reg, match_len_next;
    logic                    mismatch_reg, mismatch_next;
    logic                    expect_name_reg, expect_name_next;
    logic                    doc_seen_reg, doc_seen_next;
    logic [COUNT_BITS-1:0]   doc_counter_reg, doc_counter_next;
    logic [COUNT_BITS-1:0]   term_count_reg, term_count_next;

    sgmltok_pkg::result_t    queue_reg [DEPTH];
    logic [PTRB-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNTB-1:0]         count_reg;

    sgmltok_pkg::result_t    res0, res1, head;
    logic [1:0]              nres;
    logic                    s_accept, m_accept;
    logic [7:0]              c;
    logic [COUNT_BITS-1:0]   tc_inc, dc_inc;
    logic [EXT_BITS-1:0]     dc_ext, tc_ext, tc_inc_ext;
    logic [OUTB-1:0]         dc_out, tc_out, tc_inc_out;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign c        = s_tdata;

    assign tc_inc = (term_count_reg == '1) ? term_count_reg : term_count_reg + 1'b1;
    assign dc_inc = (doc_counter_reg == '1) ? doc_counter_reg : doc_counter_reg + 1'b1;

    assign dc_ext     = EXT_BITS'(doc_counter_reg);
    assign tc_ext     = EXT_BITS'(term_count_reg);
    assign tc_inc_ext = EXT_BITS'(tc_inc);
    assign dc_out     = dc_ext[OUTB-1:0];
    assign tc_out     = tc_ext[OUTB-1:0];
    assign tc_inc_out = tc_inc_ext[OUTB-1:0];

    always_comb
    begin
        mode_next        = mode_reg;
        match_len_next   = match_len_reg;
        mismatch_next    = mismatch_reg;
        expect_name_next = expect_name_reg;
        doc_seen_next    = doc_seen_reg;
        doc_counter_next = doc_counter_reg;
        term_count_next  = term_count_reg;
        res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_TERM_BYTE, 8'h00, '0, 1'b0, '0);
        res1 = res0;
        nres = 2'd0;

        if (s_tlast)
        begin
            if (mode_reg == sgmltok_pkg::MODE_TERM)
            begin
                res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_TERM_END, 8'h00,
                                                dc_out, doc_seen_reg, '0);
                res1 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_DOC_LEN, 8'h00,
                                                dc_out, doc_seen_reg, tc_inc_out);
                nres = 2'd2;
            end
            else if (mode_reg == sgmltok_pkg::MODE_NAME)
            begin
                res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_NAME_END, 8'h00,
                                                dc_out, doc_seen_reg, '0);
                res1 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_DOC_LEN, 8'h00,
                                                dc_out, doc_seen_reg, tc_out);
                nres = 2'd2;
            end
            else
            begin
                res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_DOC_LEN, 8'h00,
                                                dc_out, doc_seen_reg, tc_out);
                nres = 2'd1;
            end
            mode_next        = sgmltok_pkg::MODE_SKIP;
            match_len_next   = 3'd0;
            mismatch_next    = 1'b0;
            expect_name_next = 1'b0;
            doc_seen_next    = 1'b0;
            doc_counter_next = '0;
            term_count_next  = '0;
        end
        else if (mode_reg == sgmltok_pkg::MODE_TAG)
        begin
            if (c == sgmltok_pkg::CHAR_GT)
            begin
                mode_next = sgmltok_pkg::MODE_SKIP;
                if (!mismatch_reg && match_len_reg == sgmltok_pkg::TAG_DOC_LEN)
                begin
                    if (doc_seen_reg)
                    begin
                        res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_DOC_LEN, 8'h00,
                                                        dc_out, doc_seen_reg, tc_out);
                        nres = 2'd1;
                        doc_counter_next = dc_inc;
                    end
                    doc_seen_next   = 1'b1;
                    term_count_next = '0;
                end
                else if (!mismatch_reg && match_len_reg == sgmltok_pkg::TAG_DOCNO_LEN)
                begin
                    expect_name_next = 1'b1;
                end
            end
            else if (!mismatch_reg && match_len_reg < sgmltok_pkg::TAG_DOCNO_LEN
                     && c == sgmltok_pkg::tag_char(match_len_reg))
            begin
                match_len_next = match_len_reg + 3'd1;
            end
            else
            begin
                mismatch_next = 1'b1;
            end
        end
        else if (mode_reg == sgmltok_pkg::MODE_TERM && sgmltok_pkg::is_alnum(c))
        begin
            res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_TERM_BYTE,
                                            sgmltok_pkg::to_lower(c), dc_out, doc_seen_reg, '0);
            nres = 2'd1;
        end
        else if (mode_reg == sgmltok_pkg::MODE_NAME
                 && (sgmltok_pkg::is_alnum(c) || c == sgmltok_pkg::CHAR_DASH))
        begin
            res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_NAME_BYTE, c,
                                            dc_out, doc_seen_reg, '0);
            nres = 2'd1;
        end
        else
        begin
            // Close any open token, then look at the byte as a possible token start.
            if (mode_reg == sgmltok_pkg::MODE_TERM)
            begin
                term_count_next = tc_inc;
                res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_TERM_END, 8'h00,
                                                dc_out, doc_seen_reg, '0);
                nres = 2'd1;
            end
            else if (mode_reg == sgmltok_pkg::MODE_NAME)
            begin
                expect_name_next = 1'b0;
                res0 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_NAME_END, 8'h00,
                                                dc_out, doc_seen_reg, '0);
                nres = 2'd1;
            end
            mode_next = sgmltok_pkg::MODE_SKIP;

            if (c == sgmltok_pkg::CHAR_LT)
            begin
                mode_next      = sgmltok_pkg::MODE_TAG;
                match_len_next = 3'd0;
                mismatch_next  = 1'b0;
            end
            else if (sgmltok_pkg::is_alnum(c))
            begin
                if (expect_name_next)
                begin
                    mode_next = sgmltok_pkg::MODE_NAME;
                    res1 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_NAME_BYTE, c,
                                                    dc_out, doc_seen_reg, '0);
                end
                else
                begin
                    mode_next = sgmltok_pkg::MODE_TERM;
                    res1 = sgmltok_pkg::make_result(sgmltok_pkg::KIND_TERM_BYTE,
                                                    sgmltok_pkg::to_lower(c),
                                                    dc_out, doc_seen_reg, '0);
                end
                if (nres == 2'd0)
                begin
                    res0 = res1;
                    nres = 2'd1;
                end
                else
                begin
                    nres = 2'd2;
                end
            end
        end

        if (nres == 2'd2)
        begin
            res1.last = 1'b1;
        end
        else
        begin
            res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= sgmltok_pkg::MODE_SKIP;
            match_len_reg   <= 3'd0;
            mismatch_reg    <= 1'b0;
            expect_name_reg <= 1'b0;
            doc_seen_reg    <= 1'b0;
            doc_counter_reg <= '0;
            term_count_reg  <= '0;
        end
        else if (s_accept)
        begin
            mode_reg        <= mode_next;
            match_len_reg   <= match_len_next;
            mismatch_reg    <= mismatch_next;
            expect_name_reg <= expect_name_next;
            doc_seen_reg    <= doc_seen_next;
            doc_counter_reg <= doc_counter_next;
            term_count_reg  <= term_count_next;
        end
    end

    // Result queue.
    always_ff @(posedge clk)
    begin
        if (s_accept && nres != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (s_accept && nres == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTRB'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTRB'(nres);
            end
            if (m_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTRB'(1);
            end
            count_reg <= count_reg + (s_accept ? CNTB'(nres) : CNTB'(0))
                                   - (m_accept ? CNTB'(1) : CNTB'(0));
        end
    end

    assign s_tready = (count_reg <= CNTB'(DEPTH - 2));
    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{PAD_BITS{1'b0}}, head.doc_length, head.in_document,
                       head.doc_number, head.char_out};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTB'(DEPTH))
        else $error("result queue overflow");

    a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> mode_reg == sgmltok_pkg::MODE_SKIP && !doc_seen_reg
                               && doc_counter_reg == '0 && term_count_reg == '0)
        else $error("state not cleared after end of input");

    a_flush_reports: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> count_reg != '0)
        else $error("end of input gave no result");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        match_len_reg <= sgmltok_pkg::TAG_DOCNO_LEN)
        else $error("tag match length out of range");

endmodule
